// ===== design/fcbf_pkg.sv =====
`default_nettype none

package fcbf_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int CNT_W = 11;
	localparam int TOTAL_W = 48;
	localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PEEK  = 2'd1,
		OP_POP   = 2'd2,
		OP_END   = 2'd3
	} fcbf_op_t;

	typedef struct packed {
		fcbf_op_t         operation;
		logic [7:0]       data_byte;
		logic [CNT_W-1:0] amount;
	} fcbf_req_t;

	typedef struct packed {
		logic               accepted;
		logic [7:0]         peek_byte;
		logic               peek_valid;
		logic [CNT_W-1:0]   popped;
		logic [CNT_W-1:0]   fill_level;
		logic [CNT_W-1:0]   free_room;
		logic [TOTAL_W-1:0] total_written;
		logic [TOTAL_W-1:0] total_read;
		logic               input_done;
		logic               at_eof;
	} fcbf_rsp_t;

	typedef logic [CNT_W-1:0] fcbf_cap_t;

endpackage

`default_nettype wire

// ===== design/fcbf_stream_if.sv =====
`default_nettype none

interface fcbf_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/flow_controlled_byte_fifo_unit.sv =====
// Channel | Dir | Payload                               | Transfer when
// --------+-----+---------------------------------------+---------------------
// req     | in  | operation, data_byte, amount          | req.valid & req.ready
// rsp     | out | accepted .. at_eof, one per req       | rsp.valid & rsp.ready
// cfg     | in  | capacity (11 bits)                    | cfg.valid & cfg.ready
//
// One request per clock; its result sits in the output register in the next cycle.
// Peek data comes from the byte memory's registered read port in that same cycle.
// Throughput is set by the single read/write port of the byte memory: 1 item/cycle.
// Async reset clears pointers, fill, totals, ended flag; the memory is not cleared.
// A stalled rsp holds its register and drops req.ready until the result is taken.
`default_nettype none

module flow_controlled_byte_fifo_unit import fcbf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fcbf_stream_if.sink   req,
	fcbf_stream_if.source rsp,
	fcbf_stream_if.sink   cfg
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);

	fcbf_cap_t capacity_q;
	fcbf_rsp_t result;
	fcbf_rsp_t rsp_q;
	fcbf_rsp_t rsp_c;
	logic      rsp_valid_q;
	logic      fire;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	fcbf_core #(.DEPTH(DEPTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (req.payload),
		.capacity  (capacity_q),
		.result    (result),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata)
	);

	fcbf_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	// read data register only reloads on a peek transfer, so it holds under stall
	always_comb begin
		rsp_c = rsp_q;
		rsp_c.peek_byte = rsp_q.peek_valid ? mem_rdata : 8'd0;
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_c;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp.valid)
		else $error("request transfer not followed by a result");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (SW'(rsp.payload.fill_level) <= DEPTH_W))
		else $error("fill level beyond memory depth");

	a_one_effect: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot0({rsp.payload.accepted, rsp.payload.peek_valid,
			rsp.payload.popped != '0}))
		else $error("result reports more than one operation effect");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg.valid) |-> $stable(capacity_q))
		else $error("capacity changed without a configuration transfer");

endmodule

`default_nettype wire

// ===== design/fcbf_mem.sv =====
`default_nettype none

module fcbf_mem import fcbf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);

	logic [7:0] store_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/fcbf_core.sv =====
`default_nettype none

module fcbf_core import fcbf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire fcbf_req_t     item,
	input  wire fcbf_cap_t     capacity,
	output fcbf_rsp_t          result,
	output logic               mem_we,
	output logic               mem_re,
	output logic      [AW-1:0] mem_addr,
	output logic      [7:0]    mem_wdata
);

	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);

	logic [AW-1:0]      head_q, head_n;
	logic [CNT_W-1:0]   fill_q, fill_n;
	logic [TOTAL_W-1:0] wcnt_q, wcnt_n;
	logic [TOTAL_W-1:0] rcnt_q, rcnt_n;
	logic               ended_q, ended_n;

	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] pop_n;
	logic             we_c, re_c;

	// head + offset wraps once at most: offset never exceeds DEPTH
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
			input logic [CNT_W-1:0] offset);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(offset);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		cap = (SW'(capacity) > DEPTH_W) ? DEPTH_W[CNT_W-1:0] : capacity;
		pop_n = (item.amount < fill_q) ? item.amount : fill_q;

		head_n  = head_q;
		fill_n  = fill_q;
		wcnt_n  = wcnt_q;
		rcnt_n  = rcnt_q;
		ended_n = ended_q;
		we_c    = 1'b0;
		re_c    = 1'b0;
		mem_addr = head_q;
		result  = '0;

		case (item.operation)
			OP_WRITE: begin
				if (fill_q < cap) begin
					we_c     = 1'b1;
					mem_addr = slot(head_q, fill_q);
					fill_n   = fill_q + 1'b1;
					wcnt_n   = wcnt_q + 1'b1;
					result.accepted = 1'b1;
				end
			end
			OP_PEEK: begin
				if (item.amount < fill_q) begin
					re_c     = 1'b1;
					mem_addr = slot(head_q, item.amount);
					result.peek_valid = 1'b1;
				end
			end
			OP_POP: begin
				head_n = slot(head_q, pop_n);
				fill_n = fill_q - pop_n;
				rcnt_n = rcnt_q + TOTAL_W'(pop_n);
				result.popped = pop_n;
			end
			OP_END: begin
				ended_n = 1'b1;
			end
			default: begin
			end
		endcase

		result.fill_level    = fill_n;
		result.free_room     = (fill_n < cap) ? (cap - fill_n) : '0;
		result.total_written = wcnt_n;
		result.total_read    = rcnt_n;
		result.input_done    = ended_n;
		result.at_eof        = ended_n && (fill_n == '0);
	end

	assign mem_we    = fire && we_c;
	assign mem_re    = fire && re_c;
	assign mem_wdata = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
			wcnt_q  <= '0;
			rcnt_q  <= '0;
			ended_q <= 1'b0;
		end else if (fire) begin
			head_q  <= head_n;
			fill_q  <= fill_n;
			wcnt_q  <= wcnt_n;
			rcnt_q  <= rcnt_n;
			ended_q <= ended_n;
		end
	end

endmodule

`default_nettype wire

// ===== bench/flow_controlled_byte_fifo_unit_tb.sv =====
`timescale 1ns / 100ps

module flow_controlled_byte_fifo_unit_tb import fcbf_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;
	localparam int AMOUNT_MAX = (1 << CNT_W) - 1;
	localparam int SLOT_W = $clog2(DEPTH_DEF);

	// Mirrors the fifo state and queues the expected result of every accepted request.
	class byte_fifo_model;
		logic [7:0] bytes [DEPTH_DEF];
		int unsigned head;
		int unsigned fill;
		logic [TOTAL_W-1:0] wr_total;
		logic [TOTAL_W-1:0] rd_total;
		bit ended;
		fcbf_cap_t capacity;
		fcbf_rsp_t pending_results [$];
		int errors;

		function new();
			head = 0;
			fill = 0;
			wr_total = '0;
			rd_total = '0;
			ended = 1'b0;
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function void apply_request(fcbf_req_t r);
			int unsigned limit;
			int unsigned n;
			int unsigned amt;
			fcbf_rsp_t e;
			limit = (32'(capacity) > DEPTH_DEF) ? DEPTH_DEF : 32'(capacity);
			amt = 32'(r.amount);
			e = '0;
			case (r.operation)
			OP_WRITE: begin
				if (fill < limit) begin
					bytes[SLOT_W'((head + fill) % DEPTH_DEF)] = r.data_byte;
					fill++;
					wr_total++;
					e.accepted = 1'b1;
				end
			end
			OP_PEEK: begin
				if (amt < fill) begin
					e.peek_byte = bytes[SLOT_W'((head + amt) % DEPTH_DEF)];
					e.peek_valid = 1'b1;
				end
			end
			OP_POP: begin
				n = (amt < fill) ? amt : fill;
				head = (head + n) % DEPTH_DEF;
				fill -= n;
				rd_total += TOTAL_W'(n);
				e.popped = CNT_W'(n);
			end
			default: begin
				ended = 1'b1;
			end
			endcase
			e.fill_level = CNT_W'(fill);
			// room never goes negative when capacity was lowered under the fill
			e.free_room = (fill < limit) ? CNT_W'(limit - fill) : '0;
			e.total_written = wr_total;
			e.total_read = rd_total;
			e.input_done = ended;
			e.at_eof = ended && (fill == 0);
			pending_results.insert(pending_results.size(), e);
		endfunction

		function void check_field(string name, logic [TOTAL_W-1:0] want,
				logic [TOTAL_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void compare_result(fcbf_rsp_t got);
			fcbf_rsp_t want;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing outstanding: %p", got);
				errors++;
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			check_field("accepted", TOTAL_W'(want.accepted), TOTAL_W'(got.accepted));
			check_field("peek_byte", TOTAL_W'(want.peek_byte), TOTAL_W'(got.peek_byte));
			check_field("peek_valid", TOTAL_W'(want.peek_valid),
				TOTAL_W'(got.peek_valid));
			check_field("popped", TOTAL_W'(want.popped), TOTAL_W'(got.popped));
			check_field("fill_level", TOTAL_W'(want.fill_level),
				TOTAL_W'(got.fill_level));
			check_field("free_room", TOTAL_W'(want.free_room), TOTAL_W'(got.free_room));
			check_field("total_written", want.total_written, got.total_written);
			check_field("total_read", want.total_read, got.total_read);
			check_field("input_done", TOTAL_W'(want.input_done),
				TOTAL_W'(got.input_done));
			check_field("at_eof", TOTAL_W'(want.at_eof), TOTAL_W'(got.at_eof));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit hold_request;
	int burst_left;
	int cycle_count;
	byte_fifo_model board = new();

	fcbf_stream_if #(.T(fcbf_req_t)) req_ch ();
	fcbf_stream_if #(.T(fcbf_rsp_t)) rsp_ch ();
	fcbf_stream_if #(.T(fcbf_cap_t)) cfg_ch ();

	flow_controlled_byte_fifo_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[flow_controlled_byte_fifo_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.compare_result(rsp_ch.payload);
	end

	// Receiver: rotates through stall patterns; a hold request freezes it for a long stretch.
	initial begin
		int unsigned tick;
		rsp_ch.ready = 1'b0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) begin
					@(negedge clk);
					rsp_ch.ready <= 1'b0;
				end
			end else begin
				case ((tick / 150) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2: rsp_ch.ready <= ((tick % 7) < 4);
				default: rsp_ch.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	function automatic fcbf_req_t make_req(fcbf_op_t op, logic [7:0] d, fcbf_cap_t a);
		fcbf_req_t r;
		r.operation = op;
		r.data_byte = d;
		r.amount = a;
		return r;
	endfunction

	function automatic fcbf_req_t pick_request(int w_wr, int w_pk, int w_pp, int w_end);
		fcbf_req_t r;
		int roll;
		roll = $urandom_range(0, w_wr + w_pk + w_pp + w_end - 1);
		r.data_byte = 8'($urandom_range(0, 255));
		r.amount = CNT_W'($urandom_range(0, AMOUNT_MAX));
		if (roll < w_wr) begin
			r.operation = OP_WRITE;
		end else if (roll < w_wr + w_pk) begin
			r.operation = OP_PEEK;
			if (board.fill > 0 && $urandom_range(0, 4) != 0)
				r.amount = CNT_W'($urandom_range(0, board.fill - 1));
		end else if (roll < w_wr + w_pk + w_pp) begin
			r.operation = OP_POP;
			case ($urandom_range(0, 9))
			0: ;
			1, 2: r.amount = CNT_W'($urandom_range(0, board.fill));
			default: r.amount = CNT_W'($urandom_range(0, 8));
			endcase
		end else begin
			r.operation = OP_END;
		end
		return r;
	endfunction

	task automatic put_request(fcbf_req_t r);
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		board.apply_request(r);
	endtask

	task automatic send_paced(fcbf_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		put_request(r);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(fcbf_cap_t value);
		wait_for_results();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		board.capacity = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_mix(int count, int w_wr, int w_pk, int w_pp, int w_end);
		repeat (count)
			send_paced(pick_request(w_wr, w_pk, w_pp, w_end));
	endtask

	initial begin
		arst_n = 1'b0;
		hold_request = 1'b0;
		burst_left = 0;
		cycle_count = 0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty fifo, input still open
		put_request(make_req(OP_PEEK, 8'h00, 11'd0));
		put_request(make_req(OP_PEEK, 8'hFF, 11'd2047));
		put_request(make_req(OP_POP, 8'h00, 11'd0));
		put_request(make_req(OP_POP, 8'hFF, 11'd2047));
		put_request(make_req(OP_WRITE, 8'h00, 11'd0));
		put_request(make_req(OP_PEEK, 8'h00, 11'd0));
		put_request(make_req(OP_POP, 8'h00, 11'd1));
		// end of input on an empty fifo, then again
		put_request(make_req(OP_END, 8'h00, 11'd0));
		put_request(make_req(OP_END, 8'hFF, 11'd2047));
		// writes after end of input still land
		put_request(make_req(OP_WRITE, 8'hFF, 11'd2047));
		put_request(make_req(OP_WRITE, 8'hA5, 11'd0));
		put_request(make_req(OP_WRITE, 8'h5A, 11'd0));
		put_request(make_req(OP_WRITE, 8'h3C, 11'd0));
		put_request(make_req(OP_PEEK, 8'h00, 11'd0));
		put_request(make_req(OP_PEEK, 8'h00, 11'd3));
		put_request(make_req(OP_PEEK, 8'h00, 11'd4));
		put_request(make_req(OP_PEEK, 8'h00, 11'd1024));
		put_request(make_req(OP_POP, 8'h00, 11'd1));
		put_request(make_req(OP_POP, 8'h00, 11'd0));
		put_request(make_req(OP_POP, 8'h00, 11'd2047));
		put_request(make_req(OP_WRITE, 8'h81, 11'd0));

		write_capacity(11'd16);
		run_mix(60, 4, 2, 3, 1);
		wait_for_results();
		run_mix(60, 4, 2, 3, 1);

		write_capacity(CAP_RESET);
		run_mix(30, 8, 2, 1, 0);
		hold_request = 1'b1;
		run_mix(90, 8, 2, 1, 0);

		// capacity under the current fill
		write_capacity(11'd4);
		run_mix(60, 3, 3, 2, 1);
		write_capacity(11'd0);
		run_mix(40, 5, 2, 2, 1);
		write_capacity(11'd1);
		run_mix(60, 4, 3, 3, 1);

		// capacity above the depth saturates: free room counts down from the depth
		write_capacity(11'd2047);
		while (board.fill < 64) begin
			if ($urandom_range(0, 7) == 0)
				send_paced(pick_request(0, 1, 0, 0));
			else
				send_paced(make_req(OP_WRITE, 8'($urandom_range(0, 255)),
					CNT_W'($urandom_range(0, AMOUNT_MAX))));
		end
		send_paced(make_req(OP_PEEK, 8'h00, CNT_W'(board.fill - 1)));
		send_paced(make_req(OP_PEEK, 8'h00, CNT_W'(board.fill)));
		while (board.fill > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_paced(make_req(OP_WRITE, 8'($urandom_range(0, 255)), 11'd0));
			else
				send_paced(make_req(OP_POP, 8'($urandom_range(0, 255)),
					CNT_W'($urandom_range(1, 200))));
		end

		write_capacity(CNT_W'($urandom_range(2, DEPTH_DEF - 1)));
		run_mix(60, 4, 3, 3, 1);
		write_capacity(CAP_RESET);
		run_mix(30, 4, 3, 3, 1);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("[flow_controlled_byte_fifo_unit] OK");
		else
			$display("[flow_controlled_byte_fifo_unit] ERROR");
		$finish;
	end

endmodule
